/* hw/rtl/assert_macros.svh */
// assertion macros, used by the top level to check its own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge once reset is released
`define RCLI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every clock edge, reset included
`define RCLI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/rcli_pkg.sv */
// types, character codes and response frames of the radio command line interpreter
`default_nettype none

package rcli_pkg;

  localparam int RADIO_W = 4;
  localparam int NFLAGS  = 7;
  localparam int HEAD_LEN = 7;
  localparam int IDX_W   = 6;

  // control and digit characters
  localparam logic [7:0] CH_CLEAR = 8'h15;
  localparam logic [7:0] CH_XOFF  = 8'h13;
  localparam logic [7:0] CH_XON   = 8'h11;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;

  // flag commands, bit order of the notification word
  localparam logic [47:0] FLAG_CMDS [NFLAGS] = '{
    "ARAMDM", "ARAMDP", "ARCALL", "ARLINK", "ARLTBL", "ARMESS", "ARSTAT"
  };
  localparam logic [47:0] CMD_AIATBL = "AIATBL";
  localparam logic [47:0] CMD_AILTBL = "AILTBL";
  localparam logic [47:0] CMD_AXNMSG = "AXNMSG";
  localparam logic [47:0] CMD_AXLINK = "AXLINK";

  // response frames
  localparam int TABLE_LEN = 50;
  localparam int LINK_LEN  = 10;
  localparam int SHORT_LEN = 6;

  localparam logic [7:0] TABLE_FRAME [TABLE_LEN] = '{
    CH_XOFF, "A", "I", "A", "T", "B", "L", "0", "0", "1", "1", "5",
    "F", "A", "K", "1", "B", "A", "R", "2", "0", "2", "A", "0", "0", "2", "4",
    "0", "1", "2", "1", "5", "F", "A", "K", "2", "B", "A", "R",
    "2", "0", "2", "A", "0", "0", "2", "4", CH_CR, CH_LF, CH_XON
  };
  localparam logic [7:0] LINK_FRAME [LINK_LEN] = '{
    CH_XOFF, "A", "I", "L", "T", "B", "L", CH_CR, CH_LF, CH_XON
  };
  localparam logic [7:0] OK_FRAME [SHORT_LEN] = '{
    CH_XOFF, "O", "K", CH_CR, CH_LF, CH_XON
  };
  localparam logic [7:0] ERR_FRAME [SHORT_LEN] = '{
    CH_XOFF, "E", "0", CH_CR, CH_LF, CH_XON
  };

  typedef enum logic [1:0] {
    FRAME_OK,
    FRAME_ERR,
    FRAME_TABLE,
    FRAME_LINK
  } frame_t;

  typedef enum logic [2:0] {
    CMD_FLAG,
    CMD_TABLE,
    CMD_LINK,
    CMD_SILENT,
    CMD_ERR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [2:0]  flag_idx;
    logic        digit_ok;
    logic        digit_one;
  } cmd_t;

  // one pending response frame
  typedef struct packed {
    logic [RADIO_W-1:0] radio;
    frame_t             frame;
    logic [NFLAGS-1:0]  flags;
  } desc_t;

  // index of the final byte of a frame
  function automatic logic [IDX_W-1:0] frame_last(frame_t f);
    logic [IDX_W-1:0] r;
    case (f)
      FRAME_TABLE: r = IDX_W'(TABLE_LEN - 1);
      FRAME_LINK:  r = IDX_W'(LINK_LEN - 1);
      default:     r = IDX_W'(SHORT_LEN - 1);
    endcase
    return r;
  endfunction

  // byte of a frame at a given position
  function automatic logic [7:0] frame_byte(frame_t f, logic [IDX_W-1:0] idx);
    logic [7:0] b;
    b = CH_NUL;
    case (f)
      FRAME_TABLE: if (idx < IDX_W'(TABLE_LEN)) b = TABLE_FRAME[idx];
      FRAME_LINK:  if (idx < IDX_W'(LINK_LEN)) b = LINK_FRAME[idx[3:0]];
      FRAME_OK:    if (idx < IDX_W'(SHORT_LEN)) b = OK_FRAME[idx[2:0]];
      default:     if (idx < IDX_W'(SHORT_LEN)) b = ERR_FRAME[idx[2:0]];
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/radio_command_line_interpreter.sv */
// top level: input register, per-radio line store and response sequencer
// each answer passes the input register, the frame register and the output register
// throughput: one byte per cycle; a line end that answers waits only while the previous
//   frame (6, 10 or 50 bytes) is still leaving the sequencer
// reset: synchronous, clears all line counts and notification bits
`default_nettype none

`include "assert_macros.svh"

module radio_command_line_interpreter #(
  parameter int NUM_RADIOS    = 16,
  parameter int LINE_BUF_SIZE = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [rcli_pkg::RADIO_W-1:0] radio_index,
  input  logic [7:0]                   rx_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [rcli_pkg::RADIO_W-1:0] radio_index_out,
  output logic [7:0]                   tx_byte,
  output logic                         last,
  output logic [rcli_pkg::NFLAGS-1:0]  notify_flags
);

  logic                         item_valid;
  logic [rcli_pkg::RADIO_W-1:0] item_radio;
  logic [7:0]                   item_byte;
  logic                         item_go;
  logic                         desc_valid;
  logic                         desc_ready;
  rcli_pkg::desc_t              desc;
  logic                         tx_busy;

  assign in_stall = item_valid && !item_go;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_radio <= radio_index;
      item_byte  <= rx_byte;
    end
  end

  rcli_line_store #(
    .NUM_RADIOS    (NUM_RADIOS),
    .LINE_BUF_SIZE (LINE_BUF_SIZE)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .radio      (item_radio),
    .rx_byte    (item_byte),
    .item_go    (item_go),
    .desc_valid (desc_valid),
    .desc_ready (desc_ready),
    .desc       (desc)
  );

  rcli_frame_tx u_tx (
    .clk             (clk),
    .rst             (rst),
    .desc_valid      (desc_valid),
    .desc_ready      (desc_ready),
    .desc            (desc),
    .busy            (tx_busy),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .radio_index_out (radio_index_out),
    .tx_byte         (tx_byte),
    .last            (last),
    .notify_flags    (notify_flags)
  );

  // input only waits on a frame still being sent
  `RCLI_ASSERT(a_stall_needs_busy, in_stall |-> tx_busy, "input stalled with sequencer idle")
  // a new frame starts the sequencer
  `RCLI_ASSERT(a_desc_starts, (desc_valid && desc_ready) |=> tx_busy, "frame not started")
  // responses only for radios in range
  `RCLI_ASSERT_ALWAYS(a_radio_range, out_valid |-> (32'(radio_index_out) < NUM_RADIOS),
    "response for radio out of range")

endmodule

`default_nettype wire

/* hw/rtl/rcli_cmd_match.sv */
// case-insensitive match of the line head against the command set
`default_nettype none

module rcli_cmd_match (
  input  logic [rcli_pkg::HEAD_LEN-1:0][7:0] head,
  input  logic [rcli_pkg::HEAD_LEN-1:0]      have,
  output rcli_pkg::cmd_t                     cmd
);

  logic [rcli_pkg::HEAD_LEN-1:0][7:0] up;
  logic [rcli_pkg::NFLAGS-1:0]        hit;

  // first six characters against a command string, first char in the top byte
  function automatic logic eq6(logic [rcli_pkg::HEAD_LEN-1:0][7:0] h, logic [47:0] s);
    logic m;
    m = 1'b1;
    for (int k = 0; k < 6; k++) begin
      if (h[k] != s[47 - 8*k -: 8]) m = 1'b0;
    end
    return m;
  endfunction

  // missing characters read as zero, lower case folded to upper
  always_comb begin
    for (int k = 0; k < rcli_pkg::HEAD_LEN; k++) begin
      up[k] = have[k] ? head[k] : 8'h00;
      if (up[k] >= "a" && up[k] <= "z") up[k] = up[k] - 8'd32;
    end
  end

  always_comb begin
    for (int f = 0; f < rcli_pkg::NFLAGS; f++) begin
      hit[f] = eq6(up, rcli_pkg::FLAG_CMDS[f]);
    end
  end

  // command classification
  always_comb begin
    cmd.flag_idx  = 3'd0;
    cmd.digit_ok  = (up[6] == rcli_pkg::CH_ZERO) || (up[6] == rcli_pkg::CH_ONE);
    cmd.digit_one = (up[6] == rcli_pkg::CH_ONE);
    for (int f = 0; f < rcli_pkg::NFLAGS; f++) begin
      if (hit[f]) cmd.flag_idx = 3'(f);
    end
    if (|hit) begin
      cmd.kind = rcli_pkg::CMD_FLAG;
    end else if (eq6(up, rcli_pkg::CMD_AIATBL)) begin
      cmd.kind = rcli_pkg::CMD_TABLE;
    end else if (eq6(up, rcli_pkg::CMD_AILTBL)) begin
      cmd.kind = rcli_pkg::CMD_LINK;
    end else if (eq6(up, rcli_pkg::CMD_AXNMSG) || eq6(up, rcli_pkg::CMD_AXLINK)) begin
      cmd.kind = rcli_pkg::CMD_SILENT;
    end else begin
      cmd.kind = rcli_pkg::CMD_ERR;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/rcli_line_store.sv */
// per-radio line state, byte update and response selection
`default_nettype none

module rcli_line_store #(
  parameter int NUM_RADIOS    = 16,
  parameter int LINE_BUF_SIZE = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  input  logic [rcli_pkg::RADIO_W-1:0] radio,
  input  logic [7:0]                   rx_byte,
  output logic                         item_go,
  output logic                         desc_valid,
  input  logic                         desc_ready,
  output rcli_pkg::desc_t              desc
);

  localparam int MAX_RADIOS = 1 << rcli_pkg::RADIO_W;
  localparam int DEPTH      = (NUM_RADIOS < MAX_RADIOS) ? NUM_RADIOS : MAX_RADIOS;
  localparam int RIDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW         = $clog2(LINE_BUF_SIZE);

  logic [CW-1:0]                      count [DEPTH];
  logic [rcli_pkg::NFLAGS-1:0]        notif [DEPTH];
  logic [rcli_pkg::HEAD_LEN-1:0][7:0] head  [DEPTH];

  logic [RIDX_W-1:0]                  rsel;
  logic                               in_range;
  logic [CW-1:0]                      cnt;
  logic [rcli_pkg::HEAD_LEN-1:0]      have;
  logic [rcli_pkg::NFLAGS-1:0]        flags_next;
  logic                               is_clear;
  logic                               is_term;
  logic                               run;
  logic                               need_resp;
  logic                               append;
  rcli_pkg::cmd_t                     cmd;
  rcli_pkg::frame_t                   frame;

  assign in_range = 32'(radio) < NUM_RADIOS;
  assign rsel     = radio[RIDX_W-1:0];
  assign cnt      = count[rsel];

  always_comb begin
    for (int k = 0; k < rcli_pkg::HEAD_LEN; k++) begin
      have[k] = cnt > CW'(k);
    end
  end

  rcli_cmd_match u_match (
    .head (head[rsel]),
    .have (have),
    .cmd  (cmd)
  );

  // byte classes
  assign is_clear = rx_byte == rcli_pkg::CH_CLEAR;
  assign is_term  = (rx_byte == rcli_pkg::CH_CR) || (rx_byte == rcli_pkg::CH_LF) ||
                    (rx_byte == rcli_pkg::CH_NUL);
  assign run      = in_range && is_term && (cnt != '0);
  assign append   = in_range && !is_clear && !is_term && (cnt < CW'(LINE_BUF_SIZE - 1));

  // notification update and frame choice
  always_comb begin
    flags_next = notif[rsel];
    frame      = rcli_pkg::FRAME_ERR;
    case (cmd.kind)
      rcli_pkg::CMD_FLAG: begin
        if (cmd.digit_ok) begin
          flags_next[cmd.flag_idx] = cmd.digit_one;
          frame = rcli_pkg::FRAME_OK;
        end
      end
      rcli_pkg::CMD_TABLE: frame = rcli_pkg::FRAME_TABLE;
      rcli_pkg::CMD_LINK:  frame = rcli_pkg::FRAME_LINK;
      default:             frame = rcli_pkg::FRAME_ERR;
    endcase
  end

  assign need_resp  = run && (cmd.kind != rcli_pkg::CMD_SILENT);
  assign desc_valid = item_valid && need_resp;
  assign item_go    = item_valid && (!need_resp || desc_ready);

  assign desc.radio = radio;
  assign desc.frame = frame;
  assign desc.flags = flags_next;

  // count and notification registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        count[i] <= '0;
        notif[i] <= '0;
      end
    end else if (item_go && in_range) begin
      if (is_clear) begin
        count[rsel] <= '0;
      end else if (append) begin
        count[rsel] <= cnt + CW'(1);
      end else if (run) begin
        count[rsel] <= '0;
        notif[rsel] <= flags_next;
      end
    end
  end

  // head characters, only the first seven are kept
  always_ff @(posedge clk) begin
    if (item_go && append && (cnt < CW'(rcli_pkg::HEAD_LEN))) begin
      head[rsel][cnt[2:0]] <= rx_byte;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/rcli_frame_tx.sv */
// response frame sequencer with output register
`default_nettype none

module rcli_frame_tx (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         desc_valid,
  output logic                         desc_ready,
  input  rcli_pkg::desc_t              desc,
  output logic                         busy,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [rcli_pkg::RADIO_W-1:0] radio_index_out,
  output logic [7:0]                   tx_byte,
  output logic                         last,
  output logic [rcli_pkg::NFLAGS-1:0]  notify_flags
);

  logic                         active;
  rcli_pkg::desc_t              cur;
  logic [rcli_pkg::IDX_W-1:0]   idx;
  logic                         load_out;
  logic                         at_last;

  assign load_out   = active && (!out_valid || !out_stall);
  assign at_last    = idx == rcli_pkg::frame_last(cur.frame);
  assign desc_ready = !active || (load_out && at_last);
  assign busy       = active;

  // frame position
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (desc_valid && desc_ready) begin
      active <= 1'b1;
    end else if (load_out && at_last) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (desc_valid && desc_ready) begin
      cur <= desc;
      idx <= '0;
    end else if (load_out) begin
      idx <= idx + rcli_pkg::IDX_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      radio_index_out <= cur.radio;
      tx_byte         <= rcli_pkg::frame_byte(cur.frame, idx);
      last            <= at_last;
      notify_flags    <= cur.flags;
    end
  end

endmodule

`default_nettype wire

/* bench/rcli_reply_checker.sv */
// response checker for the radio command line interpreter: line model, reply queue, compare
`timescale 1ns / 1ps

module rcli_reply_checker
  import rcli_pkg::*;
#(
  parameter int NUM_RADIOS    = 16,
  parameter int LINE_BUF_SIZE = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [RADIO_W-1:0] radio_index,
  input  logic [7:0]         rx_byte,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [RADIO_W-1:0] radio_index_out,
  input  logic [7:0]         tx_byte,
  input  logic               last,
  input  logic [NFLAGS-1:0]  notify_flags,
  output int                 failures,
  output int                 outstanding,
  output int                 bytes_in,
  output int                 bytes_out,
  output int                 frames_out
);

  typedef struct packed {
    logic [RADIO_W-1:0] radio;
    logic [7:0]         data;
    logic               last;
    logic [NFLAGS-1:0]  flags;
  } reply_byte_t;

  // per-radio line state as the interpreter should hold it
  logic [7:0]        line_len    [NUM_RADIOS];
  logic [55:0]       line_head   [NUM_RADIOS];
  logic [NFLAGS-1:0] notify_state[NUM_RADIOS];

  reply_byte_t reply_q[$];

  // queue one framed answer: xoff, body, cr, lf, xon
  task automatic queue_frame(input logic [RADIO_W-1:0] r, input string body);
    int          k;
    int          n;
    logic [7:0]  b;
    reply_byte_t e;
    n = body.len() + 4;
    for (k = 0; k < n; k++) begin
      if (k == 0) b = CH_XOFF;
      else if (k <= body.len()) b = body[k-1];
      else if (k == body.len() + 1) b = CH_CR;
      else if (k == body.len() + 2) b = CH_LF;
      else b = CH_XON;
      e.radio = r;
      e.data  = b;
      e.last  = (k == n - 1);
      e.flags = notify_state[r];
      reply_q.push_back(e);
    end
  endtask

  // match the first six characters of a finished line and work out the answer
  task automatic run_line(input logic [RADIO_W-1:0] r);
    logic [47:0] cmd6;
    logic [7:0]  ch;
    logic [7:0]  seventh;
    bit          matched;
    int          k;
    cmd6    = '0;
    seventh = '0;
    matched = 0;
    for (k = 0; k < HEAD_LEN; k++) begin
      ch = (k < line_len[r]) ? line_head[r][8*k +: 8] : CH_NUL;
      if (ch >= "a" && ch <= "z") ch = ch - 8'd32;
      if (k < 6) cmd6[47-8*k -: 8] = ch;
      else seventh = ch;
    end
    for (k = 0; k < NFLAGS; k++) begin
      if (!matched && cmd6 == FLAG_CMDS[k]) begin
        matched = 1;
        if (seventh == CH_ZERO || seventh == CH_ONE) begin
          notify_state[r][k] = (seventh == CH_ONE);
          queue_frame(r, "OK");
        end else begin
          queue_frame(r, "E0");
        end
      end
    end
    if (!matched) begin
      if (cmd6 == CMD_AIATBL)
        queue_frame(r, "AIATBL00115FAK1BAR202A002401215FAK2BAR202A0024");
      else if (cmd6 == CMD_AILTBL)
        queue_frame(r, "AILTBL");
      else if (cmd6 != CMD_AXNMSG && cmd6 != CMD_AXLINK)
        queue_frame(r, "E0");
    end
  endtask

  // one received byte: clear, append, or end of line
  task automatic take_byte(input logic [RADIO_W-1:0] r, input logic [7:0] c);
    if (int'(r) < NUM_RADIOS) begin
      if (c == CH_CLEAR) begin
        line_len[r] = '0;
      end else if (c != CH_CR && c != CH_LF && c != CH_NUL) begin
        // full line drops the byte and holds the count
        if (line_len[r] < LINE_BUF_SIZE - 1) begin
          if (line_len[r] < HEAD_LEN) line_head[r][8*line_len[r] +: 8] = c;
          line_len[r] = line_len[r] + 8'd1;
        end
      end else if (line_len[r] != 0) begin
        run_line(r);
        line_len[r] = '0;
      end
    end
  endtask

  // watch both channels at the rising edge
  always @(posedge clk) begin
    int          k;
    reply_byte_t want;
    if (rst) begin
      for (k = 0; k < NUM_RADIOS; k++) begin
        line_len[k]     = '0;
        line_head[k]    = '0;
        notify_state[k] = '0;
      end
      reply_q.delete();
      failures   = 0;
      bytes_in   = 0;
      bytes_out  = 0;
      frames_out = 0;
    end else begin
      // response transfer against the oldest expected byte
      if (out_valid && !out_stall) begin
        bytes_out++;
        if (last) frames_out++;
        if (reply_q.size() == 0) begin
          failures++;
          $display("%0t unexpected response: expected none, got radio %0d byte %02h last %0b",
                   $time, radio_index_out, tx_byte, last);
        end else begin
          want = reply_q.pop_front();
          if (radio_index_out !== want.radio || tx_byte !== want.data ||
              last !== want.last || notify_flags !== want.flags) begin
            failures++;
            $display("%0t mismatch: expected radio %0d byte %02h last %0b flags %02h, got %0d %02h %0b %02h",
                     $time, want.radio, want.data, want.last, want.flags,
                     radio_index_out, tx_byte, last, notify_flags);
          end
        end
      end
      // input transfer feeds the line model
      if (in_valid && !in_stall) begin
        bytes_in++;
        take_byte(radio_index, rx_byte);
      end
    end
    outstanding = reply_q.size();
  end

endmodule

/* bench/tb_radio_command_line_interpreter.sv */
// testbench top for the radio command line interpreter: stimulus, stall mixes and verdict
`timescale 1ns / 1ps

module tb_radio_command_line_interpreter;
  import rcli_pkg::*;

  localparam int NUM_RADIOS    = 16;
  localparam int LINE_BUF_SIZE = 16;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 20;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [RADIO_W-1:0] radio_index = '0;
  logic [7:0]         rx_byte = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [RADIO_W-1:0] radio_index_out;
  logic [7:0]         tx_byte;
  logic               last;
  logic [NFLAGS-1:0]  notify_flags;

  int failures;
  int outstanding;
  int bytes_in;
  int bytes_out;
  int frames_out;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // lines in flight on two radios, interleaved byte by byte
  logic [7:0]         fresh_line[$];
  logic [7:0]         line_a[$];
  logic [7:0]         line_b[$];
  logic [RADIO_W-1:0] radio_a = '0;
  logic [RADIO_W-1:0] radio_b = 4'd1;

  radio_command_line_interpreter #(
    .NUM_RADIOS   (NUM_RADIOS),
    .LINE_BUF_SIZE(LINE_BUF_SIZE)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .radio_index    (radio_index),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .radio_index_out(radio_index_out),
    .tx_byte        (tx_byte),
    .last           (last),
    .notify_flags   (notify_flags)
  );

  rcli_reply_checker #(
    .NUM_RADIOS   (NUM_RADIOS),
    .LINE_BUF_SIZE(LINE_BUF_SIZE)
  ) u_reply_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .radio_index    (radio_index),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .radio_index_out(radio_index_out),
    .tx_byte        (tx_byte),
    .last           (last),
    .notify_flags   (notify_flags),
    .failures       (failures),
    .outstanding    (outstanding),
    .bytes_in       (bytes_in),
    .bytes_out      (bytes_out),
    .frames_out     (frames_out)
  );

  always #1 clk = ~clk;

  // receiver stalls at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses still expected",
               cycle_count, outstanding);
      $display("Regression FAIL");
      $finish;
    end
  end

  // one byte transfer, with random idle cycles ahead of it; returns at a falling edge
  task automatic send_byte(input logic [RADIO_W-1:0] r, input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    radio_index <= r;
    rx_byte     <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_text(input logic [RADIO_W-1:0] r, input string s);
    int k;
    for (k = 0; k < s.len(); k++) send_byte(r, s[k]);
  endtask

  // any byte that is neither a line end nor a clear
  function automatic logic [7:0] body_char();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while (c == CH_CR || c == CH_LF || c == CH_NUL || c == CH_CLEAR) c = 8'($urandom_range(255));
    return c;
  endfunction

  // command name with each letter in random case
  task automatic add_name(input logic [47:0] name);
    int         k;
    logic [7:0] c;
    for (k = 0; k < 6; k++) begin
      c = name[47-8*k -: 8];
      if (c >= "A" && c <= "Z" && $urandom_range(1)) c = c | 8'h20;
      fresh_line.push_back(c);
    end
  endtask

  // mostly well-formed command lines with random content, some noise
  task automatic build_line();
    int kind;
    int k;
    fresh_line.delete();
    kind = $urandom_range(99);
    if (kind < 45) begin
      add_name(FLAG_CMDS[$urandom_range(NFLAGS-1)]);
      k = $urandom_range(99);
      if (k < 70) fresh_line.push_back($urandom_range(1) ? CH_ONE : CH_ZERO);
      else if (k < 85) fresh_line.push_back(body_char());
      if (k < 85) repeat ($urandom_range(3)) fresh_line.push_back(body_char());
    end else if (kind < 52) begin
      add_name(CMD_AIATBL);
      repeat ($urandom_range(2)) fresh_line.push_back(body_char());
    end else if (kind < 60) begin
      add_name(CMD_AILTBL);
      repeat ($urandom_range(2)) fresh_line.push_back(body_char());
    end else if (kind < 68) begin
      add_name($urandom_range(1) ? CMD_AXNMSG : CMD_AXLINK);
    end else if (kind < 80) begin
      // unknown command, sometimes a near miss on the flag prefix
      if ($urandom_range(1)) begin
        fresh_line.push_back("A");
        fresh_line.push_back("R");
      end
      repeat ($urandom_range(1, 8)) fresh_line.push_back(body_char());
    end else if (kind < 88) begin
      // junk wiped by a clear, then a real command
      repeat ($urandom_range(1, 5)) fresh_line.push_back(body_char());
      fresh_line.push_back(CH_CLEAR);
      add_name(FLAG_CMDS[$urandom_range(NFLAGS-1)]);
      fresh_line.push_back($urandom_range(1) ? CH_ONE : CH_ZERO);
    end else if (kind >= 96) begin
      // raw noise, line ends and clears included
      repeat ($urandom_range(1, 8)) fresh_line.push_back(8'($urandom_range(255)));
    end
    case ($urandom_range(2))
      0:       fresh_line.push_back(CH_CR);
      1:       fresh_line.push_back(CH_LF);
      default: fresh_line.push_back(CH_NUL);
    endcase
  endtask

  task automatic random_traffic(input int count);
    int                 sent;
    logic [7:0]         c;
    logic [RADIO_W-1:0] r;
    sent = 0;
    while (sent < count) begin
      if (line_a.size() == 0) begin
        build_line();
        line_a = fresh_line;
        r = RADIO_W'($urandom_range(NUM_RADIOS-1));
        while (r == radio_b) r = RADIO_W'($urandom_range(NUM_RADIOS-1));
        radio_a = r;
      end
      if (line_b.size() == 0) begin
        build_line();
        line_b = fresh_line;
        r = RADIO_W'($urandom_range(NUM_RADIOS-1));
        while (r == radio_a) r = RADIO_W'($urandom_range(NUM_RADIOS-1));
        radio_b = r;
      end
      if ($urandom_range(1)) begin
        c = line_a.pop_front();
        send_byte(radio_a, c);
      end else begin
        c = line_b.pop_front();
        send_byte(radio_b, c);
      end
      sent++;
    end
  endtask

  initial begin
    int k;
    int j;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part, sender light and receiver heavy idling
    send_idle_pct = 13;
    recv_idle_pct = 65;
    send_byte(4'd0, CH_CR);                       // end on empty line
    send_text(4'd0, "ARAMDM1");
    send_byte(4'd0, CH_CR);
    send_text(4'd15, "arStAt1");
    send_byte(4'd15, CH_LF);
    send_text(4'd0, "ARCALL");                    // six characters, stale seventh
    send_byte(4'd0, CH_NUL);
    send_text(4'd7, "ARLINK");
    send_byte(4'd7, 8'hFF);                       // bad digit
    send_byte(4'd7, CH_CR);
    send_text(4'd3, "AIATBL");
    send_byte(4'd3, CH_CR);
    send_text(4'd3, "ailtbl");
    send_byte(4'd3, CH_LF);
    send_text(4'd9, "AXNMSG");
    send_byte(4'd9, CH_CR);
    send_text(4'd9, "axlink1");
    send_byte(4'd9, CH_CR);
    send_text(4'd12, "AB");                       // short line
    send_byte(4'd12, 8'h80);
    send_byte(4'd12, CH_CR);
    send_text(4'd2, "`ilTBL");                    // backtick is not a letter
    send_byte(4'd2, CH_CR);
    send_text(4'd5, "ARMESS");
    send_byte(4'd5, CH_CLEAR);
    send_text(4'd5, "ARLTBL1");
    send_byte(4'd5, CH_CR);
    // every flag command set, then cleared
    for (j = 0; j < 2; j++) begin
      for (k = 0; k < NFLAGS; k++) begin
        send_text(4'd10, "");
        send_byte(4'd10, FLAG_CMDS[k][47:40]);
        send_byte(4'd10, FLAG_CMDS[k][39:32]);
        send_byte(4'd10, FLAG_CMDS[k][31:24]);
        send_byte(4'd10, FLAG_CMDS[k][23:16]);
        send_byte(4'd10, FLAG_CMDS[k][15:8]);
        send_byte(4'd10, FLAG_CMDS[k][7:0]);
        send_byte(4'd10, j == 0 ? CH_ONE : CH_ZERO);
        send_byte(4'd10, CH_CR);
      end
    end
    // overlong line saturates the count
    send_text(4'd1, "ARAMDP1");
    repeat (LINE_BUF_SIZE + 4) send_byte(4'd1, body_char());
    send_byte(4'd1, CH_LF);
    send_text(4'd0, "aramdm0");
    send_byte(4'd0, CH_CR);

    // random part in three stall mixes
    random_traffic(55);
    send_idle_pct = 65;
    recv_idle_pct = 13;
    random_traffic(55);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_traffic(55);

    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d input bytes and %0d response bytes in %0d frames over %0d cycles",
             bytes_in, bytes_out, frames_out, cycle_count);
    $display("directed command set, overlong line, interleaved random lines on two radios");
    if (failures == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
